// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check on every edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/core/cau_pkg.sv -----
// Shared types and constants of the complex arithmetic unit.
package cau_pkg;

  parameter int unsigned DATA_WIDTH_DEF = 16;
  parameter int unsigned FRAC_BITS_DEF  = 8;

  typedef enum logic [2:0] {
    FUNC_ADD  = 3'd0,
    FUNC_SUB  = 3'd1,
    FUNC_MUL  = 3'd2,
    FUNC_DIV  = 3'd3,
    FUNC_CONJ = 3'd4,
    FUNC_NEG  = 3'd5,
    FUNC_MAG  = 3'd6,
    FUNC_NONE = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DIVZ = 2'd1,
    STATUS_SAT  = 2'd2
  } status_e;

endpackage

// ----- rtl/core/cau_if.sv -----
// Valid/ready channel interfaces for operand words and result words.
interface cau_in_if #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   func;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic [1:0]                   status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

// ----- rtl/core/cau_iter_pipe.sv -----
// Bit-per-stage divide (two lanes) and square root pipeline with local stall.
`include "assert_macros.svh"

module cau_iter_pipe #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int unsigned SB_WIDTH   = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [2*DATA_WIDTH-1:0] den_i,
  input  logic [2*DATA_WIDTH-1:0] rem_re_i,
  input  logic [DATA_WIDTH-1:0]   lo_re_i,
  input  logic [2*DATA_WIDTH-1:0] rem_im_i,
  input  logic [DATA_WIDTH-1:0]   lo_im_i,
  input  logic [2*DATA_WIDTH-1:0] rad_i,
  input  logic [SB_WIDTH-1:0]     sb_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [DATA_WIDTH-1:0]   q_re_o,
  output logic [DATA_WIDTH-1:0]   q_im_o,
  output logic [DATA_WIDTH-1:0]   root_o,
  output logic [SB_WIDTH-1:0]     sb_o
);
  import cau_pkg::*;

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned MW  = 2 * W;
  localparam int unsigned SRW = W + 2;
  localparam int unsigned NS  = W;

  logic [NS-1:0]       v_q;
  logic [NS-1:0]       en;
  logic [MW-1:0]       den_q    [NS];
  logic [MW-1:0]       rem_re_q [NS];
  logic [W-1:0]        lo_re_q  [NS];
  logic [MW-1:0]       rem_im_q [NS];
  logic [W-1:0]        lo_im_q  [NS];
  logic [MW-1:0]       rad_q    [NS];
  logic [SRW-1:0]      srem_q   [NS];
  logic [W-1:0]        root_q   [NS];
  logic [SB_WIDTH-1:0] sb_q     [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                in_v;
    logic [MW-1:0]       den_in, rem_re_in, rem_im_in, rad_in;
    logic [W-1:0]        lo_re_in, lo_im_in, root_in;
    logic [SRW-1:0]      srem_in;
    logic [SB_WIDTH-1:0] sb_in;
    logic [MW:0]         tr_re, tr_im;
    logic                ge_re, ge_im, ge_s;
    logic [SRW+1:0]      tr_s, trial_s;

    if (k == 0) begin : g_first
      assign in_v      = valid_i;
      assign den_in    = den_i;
      assign rem_re_in = rem_re_i;
      assign lo_re_in  = lo_re_i;
      assign rem_im_in = rem_im_i;
      assign lo_im_in  = lo_im_i;
      assign rad_in    = rad_i;
      assign srem_in   = '0;
      assign root_in   = '0;
      assign sb_in     = sb_i;
    end else begin : g_next
      assign in_v      = v_q[k-1];
      assign den_in    = den_q[k-1];
      assign rem_re_in = rem_re_q[k-1];
      assign lo_re_in  = lo_re_q[k-1];
      assign rem_im_in = rem_im_q[k-1];
      assign lo_im_in  = lo_im_q[k-1];
      assign rad_in    = rad_q[k-1];
      assign srem_in   = srem_q[k-1];
      assign root_in   = root_q[k-1];
      assign sb_in     = sb_q[k-1];
    end

    // Advance when some stage from here to the tail is empty or the tail drains.
    assign en[k] = ready_i | ~(&v_q[NS-1:k]);

    // Restoring divide step: quotient bits shift into the low word.
    assign tr_re   = {rem_re_in, lo_re_in[W-1]};
    assign ge_re   = tr_re >= {1'b0, den_in};
    assign tr_im   = {rem_im_in, lo_im_in[W-1]};
    assign ge_im   = tr_im >= {1'b0, den_in};
    // Digit-by-digit square root step, two radicand bits per stage.
    assign tr_s    = {srem_in, rad_in[MW-1:MW-2]};
    assign trial_s = (SRW+2)'({root_in, 2'b01});
    assign ge_s    = tr_s >= trial_s;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && in_v) begin
        den_q[k]    <= den_in;
        rem_re_q[k] <= MW'(ge_re ? tr_re - {1'b0, den_in} : tr_re);
        lo_re_q[k]  <= {lo_re_in[W-2:0], ge_re};
        rem_im_q[k] <= MW'(ge_im ? tr_im - {1'b0, den_in} : tr_im);
        lo_im_q[k]  <= {lo_im_in[W-2:0], ge_im};
        rad_q[k]    <= rad_in << 2;
        srem_q[k]   <= SRW'(ge_s ? tr_s - trial_s : tr_s);
        root_q[k]   <= {root_in[W-2:0], ge_s};
        sb_q[k]     <= sb_in;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign q_re_o  = lo_re_q[NS-1];
  assign q_im_o  = lo_im_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign sb_o    = sb_q[NS-1];

  `ASSERT_ALWAYS(a_stall_only_at_tail, clk_i, !ready_o |-> (valid_o && !ready_i))
  `ASSERT_RST(a_accept_fills_head, clk_i, rst_ni, (valid_i && ready_o) |=> v_q[0])
  `ASSERT_RST(a_tail_holds, clk_i, rst_ni, (valid_o && !ready_i) |=> (valid_o && $stable(q_re_o) && $stable(root_o)))

endmodule

// ----- rtl/core/complex_arithmetic_unit.sv -----
// Top level of the pipelined complex arithmetic unit.
`include "assert_macros.svh"

// Complex arithmetic unit: takes one operand word per cycle while ready (operation code plus
// complex operands A and B in signed fixed point, FRAC_BITS fractional bits) and
// returns one result word per operand word, in order: A+B, A-B, A*B, A/B, conj(A),
// -A or |A| (imaginary part zero). Parts outside the DATA_WIDTH range saturate and
// report status 2; a divide with B equal to zero returns zeros with status 1; an
// unused code returns zeros with status 0. Throughput is one word per cycle
// while the output is not stalled. The stages, in order: product, sum,
// divide setup, then DATA_WIDTH divide/square-root stages that each retire one
// quotient and one root bit, then the saturating output register. Every stage
// has its own valid bit, so a stalled output lets bubbles close up and the input
// stays ready while any stage is empty.
module complex_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cau_in_if.sink     in_i,
  cau_out_if.source  out_o
);
  import cau_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned MW = 2 * W;     // magnitudes of products and their sums
  localparam int unsigned SW = 2 * W + 1; // signed sum of two products
  localparam int unsigned NW = MW + F;    // numerator scaled by 2^F

  localparam logic [W-1:0]  RES_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  RES_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [MW-1:0] MAG_POS = MW'(RES_MAX);
  localparam logic [MW-1:0] MAG_NEG = MW'(RES_MIN);

  typedef struct packed {
    func_e                func;
    logic signed [W-1:0]  a_re;
    logic signed [W-1:0]  a_im;
    logic signed [W-1:0]  b_re;
    logic signed [W-1:0]  b_im;
    logic signed [MW-1:0] p_rr;
    logic signed [MW-1:0] p_ii;
    logic signed [MW-1:0] p_ri;
    logic signed [MW-1:0] p_ir;
    logic signed [MW-1:0] sq_r;
    logic signed [MW-1:0] sq_i;
  } s1_t;

  typedef struct packed {
    func_e         func;
    logic          re_neg;
    logic [MW-1:0] re_mag;
    logic          im_neg;
    logic [MW-1:0] im_mag;
    logic [MW-1:0] rad;
  } s2_t;

  // Words that ride alongside the divide/root pipeline.
  typedef struct packed {
    func_e         func;
    logic          re_neg;
    logic [MW-1:0] re_mag;
    logic          im_neg;
    logic [MW-1:0] im_mag;
    logic          dz;
    logic          ovf_re;
    logic          ovf_im;
  } sb_t;

  typedef struct packed {
    logic [MW-1:0] den;
    logic [MW-1:0] rem_re;
    logic [W-1:0]  lo_re;
    logic [MW-1:0] rem_im;
    logic [W-1:0]  lo_im;
    sb_t           sb;
  } s3_t;

  typedef struct packed {
    logic [W-1:0] res_re;
    logic [W-1:0] res_im;
    status_e      status;
  } out_t;

  logic  s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic  s1_en, s2_en, s3_en, out_en;
  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  s3_t   s3_d, s3_q;
  out_t  out_d, out_q;

  logic          pipe_ready, pipe_valid;
  logic [W-1:0]  q_re, q_im, root;
  logic [$bits(sb_t)-1:0] pipe_sb;
  sb_t           fin_sb;

  // Hold a stage only while it is full and the stage after it is held.
  assign out_en    = !out_v_q || out_o.ready;
  assign s3_en     = !s3_v_q || pipe_ready;
  assign s2_en     = !s2_v_q || s3_en;
  assign s1_en     = !s1_v_q || s2_en;
  assign in_i.ready = s1_en;

  // Stage 1: all products, squares shared between divide and magnitude.
  always_comb begin
    s1_d.func = func_e'(in_i.func);
    s1_d.a_re = in_i.a_re;
    s1_d.a_im = in_i.a_im;
    s1_d.b_re = in_i.b_re;
    s1_d.b_im = in_i.b_im;
    s1_d.p_rr = MW'(in_i.a_re) * MW'(in_i.b_re);
    s1_d.p_ii = MW'(in_i.a_im) * MW'(in_i.b_im);
    s1_d.p_ri = MW'(in_i.a_re) * MW'(in_i.b_im);
    s1_d.p_ir = MW'(in_i.a_im) * MW'(in_i.b_re);
    if (s1_d.func == FUNC_MAG) begin
      s1_d.sq_r = MW'(in_i.a_re) * MW'(in_i.a_re);
      s1_d.sq_i = MW'(in_i.a_im) * MW'(in_i.a_im);
    end else begin
      s1_d.sq_r = MW'(in_i.b_re) * MW'(in_i.b_re);
      s1_d.sq_i = MW'(in_i.b_im) * MW'(in_i.b_im);
    end
  end

  // Stage 2: per-operation sums, then split into sign and magnitude.
  always_comb begin
    logic signed [SW-1:0] re_x;
    logic signed [SW-1:0] im_x;
    re_x = '0;
    im_x = '0;
    case (s1_q.func)
      FUNC_ADD: begin
        re_x = SW'(s1_q.a_re) + SW'(s1_q.b_re);
        im_x = SW'(s1_q.a_im) + SW'(s1_q.b_im);
      end
      FUNC_SUB: begin
        re_x = SW'(s1_q.a_re) - SW'(s1_q.b_re);
        im_x = SW'(s1_q.a_im) - SW'(s1_q.b_im);
      end
      FUNC_MUL: begin
        re_x = SW'(s1_q.p_rr) - SW'(s1_q.p_ii);
        im_x = SW'(s1_q.p_ri) + SW'(s1_q.p_ir);
      end
      FUNC_DIV: begin
        re_x = SW'(s1_q.p_rr) + SW'(s1_q.p_ii);
        im_x = SW'(s1_q.p_ir) - SW'(s1_q.p_ri);
      end
      FUNC_CONJ: begin
        re_x = SW'(s1_q.a_re);
        im_x = -SW'(s1_q.a_im);
      end
      FUNC_NEG: begin
        re_x = -SW'(s1_q.a_re);
        im_x = -SW'(s1_q.a_im);
      end
      default: begin
        re_x = '0;
        im_x = '0;
      end
    endcase
    s2_d.func   = s1_q.func;
    s2_d.re_neg = re_x[SW-1];
    s2_d.re_mag = re_x[SW-1] ? MW'(-re_x) : MW'(re_x);
    s2_d.im_neg = im_x[SW-1];
    s2_d.im_mag = im_x[SW-1] ? MW'(-im_x) : MW'(im_x);
    s2_d.rad    = $unsigned(s1_q.sq_r) + $unsigned(s1_q.sq_i);
  end

  // Stage 3: divide setup (overflow check, first remainder), product scaling.
  always_comb begin
    logic [NW-1:0] num_re, num_im, hi_re, hi_im;
    num_re = NW'(s2_q.re_mag) << F;
    num_im = NW'(s2_q.im_mag) << F;
    hi_re  = num_re >> W;
    hi_im  = num_im >> W;
    s3_d.den    = s2_q.rad;
    s3_d.rem_re = hi_re[MW-1:0];
    s3_d.lo_re  = num_re[W-1:0];
    s3_d.rem_im = hi_im[MW-1:0];
    s3_d.lo_im  = num_im[W-1:0];
    s3_d.sb.func   = s2_q.func;
    s3_d.sb.re_neg = s2_q.re_neg;
    s3_d.sb.im_neg = s2_q.im_neg;
    // Truncate toward zero: shift the magnitude, keep the sign.
    if (s2_q.func == FUNC_MUL) begin
      s3_d.sb.re_mag = s2_q.re_mag >> F;
      s3_d.sb.im_mag = s2_q.im_mag >> F;
    end else begin
      s3_d.sb.re_mag = s2_q.re_mag;
      s3_d.sb.im_mag = s2_q.im_mag;
    end
    s3_d.sb.dz     = s2_q.rad == '0;
    // A quotient of 2^W or more only ever saturates.
    s3_d.sb.ovf_re = hi_re >= NW'(s2_q.rad);
    s3_d.sb.ovf_im = hi_im >= NW'(s2_q.rad);
  end

  cau_iter_pipe #(
    .DATA_WIDTH (W),
    .SB_WIDTH   ($bits(sb_t))
  ) u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s3_v_q),
    .ready_o  (pipe_ready),
    .den_i    (s3_q.den),
    .rem_re_i (s3_q.rem_re),
    .lo_re_i  (s3_q.lo_re),
    .rem_im_i (s3_q.rem_im),
    .lo_im_i  (s3_q.lo_im),
    .rad_i    (s3_q.den),
    .sb_i     (s3_q.sb),
    .valid_o  (pipe_valid),
    .ready_i  (out_en),
    .q_re_o   (q_re),
    .q_im_o   (q_im),
    .root_o   (root),
    .sb_o     (pipe_sb)
  );

  assign fin_sb = sb_t'(pipe_sb);

  // Clip a sign/magnitude value to the result range; top bit flags a clip.
  function automatic logic [W:0] saturate(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] m;
    logic [MW-1:0] neg_m;
    logic          sat;
    m   = mag;
    sat = 1'b0;
    if (!neg && mag > MAG_POS) begin
      m   = MAG_POS;
      sat = 1'b1;
    end else if (neg && mag > MAG_NEG) begin
      m   = MAG_NEG;
      sat = 1'b1;
    end
    neg_m = -m;
    return {sat, neg ? neg_m[W-1:0] : m[W-1:0]};
  endfunction

  // Output stage: pick the result source, saturate, set status.
  always_comb begin
    logic          re_neg, im_neg;
    logic [MW-1:0] re_mag, im_mag;
    logic [W:0]    sat_re, sat_im;
    re_neg = fin_sb.re_neg;
    im_neg = fin_sb.im_neg;
    re_mag = fin_sb.re_mag;
    im_mag = fin_sb.im_mag;
    if (fin_sb.func == FUNC_DIV) begin
      re_mag = fin_sb.ovf_re ? '1 : MW'(q_re);
      im_mag = fin_sb.ovf_im ? '1 : MW'(q_im);
    end else if (fin_sb.func == FUNC_MAG) begin
      re_neg = 1'b0;
      re_mag = MW'(root);
      im_neg = 1'b0;
      im_mag = '0;
    end
    sat_re = saturate(re_neg, re_mag);
    sat_im = saturate(im_neg, im_mag);
    if (fin_sb.func == FUNC_DIV && fin_sb.dz) begin
      out_d.res_re = '0;
      out_d.res_im = '0;
      out_d.status = STATUS_DIVZ;
    end else begin
      out_d.res_re = sat_re[W-1:0];
      out_d.res_im = sat_im[W-1:0];
      out_d.status = (sat_re[W] || sat_im[W]) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_q <= in_i.valid;
      end
      if (s2_en) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_en) begin
        s3_v_q <= s2_v_q;
      end
      if (out_en) begin
        out_v_q <= pipe_valid;
      end
    end
  end

  // Load a payload only with a valid word behind it.
  always_ff @(posedge clk_i) begin
    if (s1_en && in_i.valid) begin
      s1_q <= s1_d;
    end
    if (s2_en && s1_v_q) begin
      s2_q <= s2_d;
    end
    if (s3_en && s2_v_q) begin
      s3_q <= s3_d;
    end
    if (out_en && pipe_valid) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.res_re = out_q.res_re;
  assign out_o.res_im = out_q.res_im;
  assign out_o.status = out_q.status;

  `ASSERT_RST(a_divz_gives_zero, clk_i, rst_ni, (out_o.valid && out_o.status == STATUS_DIVZ) |-> (out_o.res_re == '0 && out_o.res_im == '0))
  `ASSERT_ALWAYS(a_ready_when_drained, clk_i, !out_v_q |-> in_i.ready)
  `ASSERT_RST(a_sat_at_limit, clk_i, rst_ni, (out_o.valid && out_o.status == STATUS_SAT) |-> (out_o.res_re == RES_MAX || out_o.res_re == RES_MIN || out_o.res_im == RES_MAX || out_o.res_im == RES_MIN))

endmodule

// ----- test/complex_arithmetic_unit_test.sv -----
// Self-checking testbench for the complex arithmetic unit.
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam int unsigned DW = DATA_WIDTH_DEF;
  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam longint POS_MAX = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint NEG_MIN = -(64'sd1 <<< (DW - 1));
  // Pipeline depth is DATA_WIDTH + 4; leave margin when draining.
  localparam int DRAIN_CYCLES = DW + 20;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    status_e              status;
  } result_t;

  logic clk_i;
  logic rst_ni;

  cau_in_if  #(.DATA_WIDTH(DW)) in_if ();
  cau_out_if #(.DATA_WIDTH(DW)) out_if ();

  complex_arithmetic_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Results still owed by the unit, oldest first.
  result_t pending_results[$];
  bit      mismatch_seen;
  int      send_idle_pct;
  int      recv_stall_pct;
  bit      recv_hold;
  int      quiet_cycles;

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp one part to the data range; flag it when it had to be clamped.
  function automatic logic signed [DW-1:0] clamp_part(input longint v, inout bit sat);
    if (v > POS_MAX) begin
      sat = 1'b1;
      return POS_MAX[DW-1:0];
    end
    if (v < NEG_MIN) begin
      sat = 1'b1;
      return NEG_MIN[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Drop the fraction bits of a product sum, rounding toward zero.
  function automatic longint scale_down(input longint v);
    if (v < 0) return -((-v) >>> FB);
    return v >>> FB;
  endfunction

  // Fixed-point quotient num * 2^FB / den, rounding toward zero.
  function automatic longint fixed_quotient(input longint num, input longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag <<< FB) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint int_sqrt(input longint n);
    longint root;
    longint trial;
    root = 0;
    for (int b = DW; b >= 0; b--) begin
      trial = root | (64'sd1 <<< b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic result_t compute_result(input logic [2:0] func,
                                             input logic signed [DW-1:0] a_re,
                                             input logic signed [DW-1:0] a_im,
                                             input logic signed [DW-1:0] b_re,
                                             input logic signed [DW-1:0] b_im);
    longint  ar, ai, br, bi, re, im, den;
    bit      sat;
    result_t r;
    ar = a_re;
    ai = a_im;
    br = b_re;
    bi = b_im;
    re = 0;
    im = 0;
    sat = 1'b0;
    r.status = STATUS_OK;
    case (func_e'(func))
      FUNC_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      FUNC_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      FUNC_MUL: begin
        re = scale_down(ar * br - ai * bi);
        im = scale_down(ar * bi + ai * br);
      end
      FUNC_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = STATUS_DIVZ;
        end else begin
          re = fixed_quotient(ar * br + ai * bi, den);
          im = fixed_quotient(ai * br - ar * bi, den);
        end
      end
      FUNC_CONJ: begin
        re = ar;
        im = -ai;
      end
      FUNC_NEG: begin
        re = -ar;
        im = -ai;
      end
      FUNC_MAG: begin
        re = int_sqrt(ar * ar + ai * ai);
      end
      default: begin
      end
    endcase
    r.res_re = clamp_part(re, sat);
    r.res_im = clamp_part(im, sat);
    if (r.status == STATUS_OK && sat) r.status = STATUS_SAT;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one operand word; call and return at a falling edge. Valid stays high
  // on return so back-to-back words do not toggle it.
  task automatic send_word(input logic [2:0] func,
                           input logic signed [DW-1:0] a_re,
                           input logic signed [DW-1:0] a_im,
                           input logic signed [DW-1:0] b_re,
                           input logic signed [DW-1:0] b_im);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.func  = func;
    in_if.a_re  = a_re;
    in_if.a_im  = a_im;
    in_if.b_re  = b_re;
    in_if.b_im  = b_im;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_results.push_back(compute_result(func, a_re, a_im, b_re, b_im));
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_if.valid = 1'b0;
  endtask

  // Hold until every owed result has come back.
  task automatic wait_drained();
    stop_sending();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Operand values lean toward the edges of the range and toward small numbers.
  function automatic logic signed [DW-1:0] pick_operand();
    case ($urandom_range(7))
      0: return NEG_MIN[DW-1:0];
      1: return POS_MAX[DW-1:0];
      2: return '0;
      3: return DW'($signed($urandom_range(1024)) - 512);
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_func();
    // Unused code only now and then.
    if ($urandom_range(31) == 0) return FUNC_NONE;
    return 3'($urandom_range(FUNC_MAG));
  endfunction

  task automatic send_random(input int count);
    logic signed [DW-1:0] br, bi;
    for (int n = 0; n < count; n++) begin
      br = pick_operand();
      bi = pick_operand();
      // Zero divisors occasionally, otherwise whatever falls out.
      if ($urandom_range(15) == 0) begin
        br = '0;
        bi = '0;
      end
      send_word(pick_func(), pick_operand(), pick_operand(), br, bi);
    end
  endtask

  // Receiver: stall at random, or hold ready low while a hold-off runs.
  always @(negedge clk_i) begin
    out_if.ready = !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: re %0d im %0d status %0d",
               out_if.res_re, out_if.res_im, out_if.status);
        mismatch_seen = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_if.res_re !== want.res_re) begin
          $error("res_re expected %0d got %0d", want.res_re, out_if.res_re);
          mismatch_seen = 1'b1;
        end
        if (out_if.res_im !== want.res_im) begin
          $error("res_im expected %0d got %0d", want.res_im, out_if.res_im);
          mismatch_seen = 1'b1;
        end
        if (out_if.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_if.status);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Edges of every operation and the listed corner cases.
  task automatic test_directed();
    logic signed [DW-1:0] mx, mn;
    mx = POS_MAX[DW-1:0];
    mn = NEG_MIN[DW-1:0];
    send_word(FUNC_ADD, mx, mx, mx, 16'sd1);        // both parts saturate high
    send_word(FUNC_ADD, mn, mn, mn, -16'sd1);       // both parts saturate low
    send_word(FUNC_ADD, 16'sd256, -16'sd512, 16'sd3, 16'sd7);
    send_word(FUNC_SUB, mn, mx, mx, mn);
    send_word(FUNC_SUB, 16'sd100, 16'sd200, 16'sd300, -16'sd50);
    send_word(FUNC_MUL, mx, mx, mx, mx);
    send_word(FUNC_MUL, mn, mn, mn, mn);
    send_word(FUNC_MUL, 16'sd384, -16'sd128, -16'sd3, 16'sd5); // truncates to -2 + 9i
    send_word(FUNC_MUL, -16'sd1, 16'sd1, 16'sd1, 16'sd1);
    send_word(FUNC_DIV, 16'sd256, 16'sd256, 16'sd0, 16'sd0);  // divide by zero
    send_word(FUNC_DIV, mx, mn, 16'sd1, 16'sd0);              // tiny divisor
    send_word(FUNC_DIV, 16'sd512, 16'sd256, 16'sd256, 16'sd256);
    send_word(FUNC_DIV, -16'sd700, 16'sd33, mn, mx);
    send_word(FUNC_DIV, mn, mn, mn, mn);
    send_word(FUNC_CONJ, mn, mn, 16'sd0, 16'sd0);             // negate most negative
    send_word(FUNC_CONJ, mx, mx, mx, mx);
    send_word(FUNC_NEG, mn, mx, mx, mn);
    send_word(FUNC_NEG, 16'sd5, -16'sd9, 16'sd0, 16'sd0);
    send_word(FUNC_MAG, mn, mn, mx, mx);                      // magnitude saturates
    send_word(FUNC_MAG, 16'sd3, -16'sd4, 16'sd0, 16'sd0);
    send_word(FUNC_MAG, 16'sd0, 16'sd0, mn, mn);
    send_word(FUNC_NONE, mx, mn, mx, mn);
    send_word(FUNC_NONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    wait_drained();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    send_random(count);
    wait_drained();
  endtask

  // Hold the receiver off long enough that the pipeline fills and stalls input.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (200) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      send_random(150);
    join
    wait_drained();
  endtask

  // Bursts separated by pauses in which every owed result drains.
  task automatic test_drain_pauses();
    send_idle_pct  = 10;
    recv_stall_pct = 30;
    for (int burst = 0; burst < 5; burst++) begin
      send_random($urandom_range(5, 40));
      wait_drained();
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    recv_hold      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_seen  = 1'b0;
    quiet_cycles   = 0;
    in_if.valid    = 1'b0;
    in_if.func     = '0;
    in_if.a_re     = '0;
    in_if.a_im     = '0;
    in_if.b_re     = '0;
    in_if.b_im     = '0;
    out_if.ready   = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_phase(0, 0, 350);
    test_random_phase(50, 0, 350);
    test_random_phase(0, 50, 350);
    test_random_phase(20, 20, 350);
    test_backpressure();
    test_drain_pauses();

    stop_sending();
    recv_hold = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!mismatch_seen && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
